FILE: hdl/fsi_pkg.sv
// Shared constants, field widths, side-band structs and the quarter-wave table
// for the fixed-point sine pipeline. No dependencies.
package fsi_pkg;

   localparam int PI_UNITS_DEF      = 6399;
   localparam int HALF_PI_UNITS_DEF = 3200;
   localparam int TWO_PI_UNITS_DEF  = 12799;

   localparam int TABLE_STEPS   = 32;
   localparam int TABLE_STEPS_W = 5;
   localparam int IDX_W         = 6;
   localparam int SINE_ONE      = 2037;

   localparam int ANGLE_W = 32;
   localparam int REM_W   = 33;
   localparam int MOD_W   = 17;
   localparam int MID_W   = 18;
   localparam int WRAP_W  = 19;
   localparam int FOLD_W  = 16;
   localparam int TAB_W   = 11;
   localparam int DIFF_W  = 7;
   localparam int DX_W    = 11;
   localparam int NUM_W   = 17;
   localparam int QUO_W   = 13;
   localparam int RES_W   = 12;
   localparam int RSP_DATA_W = 16;

   localparam int RECIP_SHIFT   = 28;
   localparam int RECIP_W       = 29;
   localparam int RED_PER_STAGE = 7;

   typedef struct packed {
      logic                    below;
      logic                    above;
      logic signed [MID_W-1:0] mid;
   } wrap_side_type;

   typedef struct packed {
      logic              neg;
      logic [FOLD_W-1:0] angle;
   } fold_type;

   function automatic logic [TAB_W-1:0] quarter_wave(input logic [IDX_W-1:0] idx);
      logic [TAB_W-1:0] val;
      case (idx)
         6'd0:    val = 11'd0;
         6'd1:    val = 11'd100;
         6'd2:    val = 11'd200;
         6'd3:    val = 11'd299;
         6'd4:    val = 11'd397;
         6'd5:    val = 11'd495;
         6'd6:    val = 11'd591;
         6'd7:    val = 11'd686;
         6'd8:    val = 11'd780;
         6'd9:    val = 11'd871;
         6'd10:   val = 11'd960;
         6'd11:   val = 11'd1047;
         6'd12:   val = 11'd1132;
         6'd13:   val = 11'd1214;
         6'd14:   val = 11'd1292;
         6'd15:   val = 11'd1368;
         6'd16:   val = 11'd1440;
         6'd17:   val = 11'd1509;
         6'd18:   val = 11'd1575;
         6'd19:   val = 11'd1636;
         6'd20:   val = 11'd1694;
         6'd21:   val = 11'd1747;
         6'd22:   val = 11'd1797;
         6'd23:   val = 11'd1842;
         6'd24:   val = 11'd1882;
         6'd25:   val = 11'd1918;
         6'd26:   val = 11'd1949;
         6'd27:   val = 11'd1976;
         6'd28:   val = 11'd1998;
         6'd29:   val = 11'd2015;
         6'd30:   val = 11'd2027;
         6'd31:   val = 11'd2035;
         default: val = 11'd2037;
      endcase
      return val;
   endfunction

endpackage

FILE: hdl/fsi_mod_stage.sv
// One registered slice of the restoring reduction of the offset angle modulo
// two pi. Depends on fsi_pkg.
module fsi_mod_stage #(
   parameter int TWO_PI_UNITS = fsi_pkg::TWO_PI_UNITS_DEF,
   parameter int TOP_SHIFT    = 0,
   parameter int STEPS        = fsi_pkg::RED_PER_STAGE
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  logic [fsi_pkg::REM_W-1:0] up_rem,
   input  fsi_pkg::wrap_side_type    up_side,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output logic [fsi_pkg::REM_W-1:0] dn_rem,
   output fsi_pkg::wrap_side_type    dn_side
);

   localparam int RW = fsi_pkg::REM_W;

   logic                   valid_ff, valid_in;
   logic [RW-1:0]          rem_ff, rem_in;
   fsi_pkg::wrap_side_type side_ff, side_in;
   logic                   load;

   assign load     = !valid_ff || dn_ready;
   assign up_ready = load;
   assign valid_in = load ? up_valid : valid_ff;
   assign side_in  = up_side;

   always_comb begin
      rem_in = up_rem;
      for (int j = 0; j < STEPS; j++) begin
         if (TOP_SHIFT - j >= 0) begin
            if (64'(rem_in) >= (64'(TWO_PI_UNITS) << (TOP_SHIFT - j))) begin
               rem_in = rem_in - RW'(64'(TWO_PI_UNITS) << (TOP_SHIFT - j));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_valid) begin
         rem_ff  <= rem_in;
         side_ff <= side_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_side  = side_ff;

endmodule

FILE: hdl/fsi_fold.sv
// Two stages: rebuild the wrapped angle from the remainder, then fold it into
// the first quarter wave with sign. Depends on fsi_pkg.
module fsi_fold #(
   parameter int PI_UNITS      = fsi_pkg::PI_UNITS_DEF,
   parameter int HALF_PI_UNITS = fsi_pkg::HALF_PI_UNITS_DEF,
   parameter int TWO_PI_UNITS  = fsi_pkg::TWO_PI_UNITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  logic [fsi_pkg::REM_W-1:0] up_rem,
   input  fsi_pkg::wrap_side_type    up_side,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output fsi_pkg::fold_type         dn_fold
);

   localparam int RW       = fsi_pkg::WRAP_W;
   localparam int FW       = fsi_pkg::FOLD_W;
   localparam int MW       = fsi_pkg::MOD_W;
   localparam int TWICE_PI = 2 * PI_UNITS;
   localparam int CSHIFT   = TWICE_PI % TWO_PI_UNITS;

   localparam logic [RW-1:0] PI_W = RW'(PI_UNITS);
   localparam logic [RW-1:0] A_LO = RW'(-PI_UNITS);
   localparam logic [RW-1:0] A_HI = RW'(-PI_UNITS - TWO_PI_UNITS);
   localparam logic [RW-1:0] B_GE = RW'(PI_UNITS - TWO_PI_UNITS - CSHIFT);
   localparam logic [RW-1:0] B_LT = RW'(PI_UNITS - CSHIFT);

   logic              wv_ff, wv_in;
   logic [RW-1:0]     wrap_ff, wrap_in;
   logic              fv_ff, fv_in;
   fsi_pkg::fold_type fold_ff, fold_in;
   logic              load_w, load_f;
   logic [MW-1:0]     r1;
   logic [RW-1:0]     r1_ext, wa, wb;
   logic [RW-1:0]     mag, mir;

   assign load_f   = !fv_ff || dn_ready;
   assign load_w   = !wv_ff || load_f;
   assign up_ready = load_w;
   assign wv_in    = load_w ? up_valid : wv_ff;
   assign fv_in    = load_f ? wv_ff : fv_ff;

   always_comb begin
      r1     = up_rem[MW-1:0];
      r1_ext = RW'(r1);
      if (32'(r1) > 32'(TWICE_PI)) begin
         wa = r1_ext + A_HI;
      end else begin
         wa = r1_ext + A_LO;
      end
      if (32'(r1) == 32'(CSHIFT)) begin
         wb = PI_W;
      end else if (32'(r1) >= 32'(CSHIFT)) begin
         wb = r1_ext + B_GE;
      end else begin
         wb = r1_ext + B_LT;
      end
      if (up_side.below) begin
         wrap_in = wa;
      end else if (up_side.above) begin
         wrap_in = wb;
      end else begin
         wrap_in = {up_side.mid[fsi_pkg::MID_W-1], up_side.mid};
      end
   end

   always_comb begin
      fold_in.neg = wrap_ff[RW-1];
      mag = wrap_ff[RW-1] ? (~wrap_ff + 1'b1) : wrap_ff;
      if (32'(mag) > 32'(HALF_PI_UNITS)) begin
         mir = PI_W - mag;
      end else begin
         mir = mag;
      end
      if (mir[RW-1]) begin
         fold_in.angle = '0;
      end else if (32'(mir) > 32'(HALF_PI_UNITS)) begin
         fold_in.angle = FW'(HALF_PI_UNITS);
      end else begin
         fold_in.angle = mir[FW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff <= 1'b0;
         fv_ff <= 1'b0;
      end else begin
         wv_ff <= wv_in;
         fv_ff <= fv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_w && up_valid) begin
         wrap_ff <= wrap_in;
      end
      if (load_f && wv_ff) begin
         fold_ff <= fold_in;
      end
   end

   assign dn_valid = fv_ff;
   assign dn_fold  = fold_ff;

   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      up_valid |-> 64'(up_rem) < 64'(TWO_PI_UNITS))
      else $error("remainder not reduced below two pi");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      fv_ff |-> 32'(fold_ff.angle) <= 32'(HALF_PI_UNITS))
      else $error("folded angle beyond half pi");

endmodule

FILE: hdl/fsi_interp.sv
// Table lookup and linear interpolation over five stages: index search, table read,
// rounded slope multiply, reciprocal divide, clamp and sign. Depends on fsi_pkg.
module fsi_interp #(
   parameter int HALF_PI_UNITS = fsi_pkg::HALF_PI_UNITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  fsi_pkg::fold_type         up_fold,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output logic [fsi_pkg::RES_W-1:0] dn_sine
);

   localparam int IW    = fsi_pkg::IDX_W;
   localparam int FW    = fsi_pkg::FOLD_W;
   localparam int TW    = fsi_pkg::TAB_W;
   localparam int DW    = fsi_pkg::DIFF_W;
   localparam int XW    = fsi_pkg::DX_W;
   localparam int NW    = fsi_pkg::NUM_W;
   localparam int QW    = fsi_pkg::QUO_W;
   localparam int RW    = fsi_pkg::RES_W;
   localparam int SW    = FW + fsi_pkg::TABLE_STEPS_W;
   localparam int PW    = NW + fsi_pkg::RECIP_W;
   localparam int SUM_W = QW + 1;
   localparam int STEP_UNITS = HALF_PI_UNITS / fsi_pkg::TABLE_STEPS;
   localparam int HALF_STEP  = STEP_UNITS / 2;
   localparam longint RECIP_L =
      ((64'd1 << fsi_pkg::RECIP_SHIFT) + STEP_UNITS - 1) / STEP_UNITS;
   localparam logic [fsi_pkg::RECIP_W-1:0] RECIP = fsi_pkg::RECIP_W'(RECIP_L);

   logic              load_i, load_d, load_m, load_q, load_o;
   logic              iv_ff, iv_in, dv_ff, dv_in, mv_ff, mv_in;
   logic              qv_ff, qv_in, ov_ff, ov_in;

   logic [IW-1:0]     idx_ff, idx_in;
   logic [FW-1:0]     ang_ff;
   logic              neg_i_ff;
   logic [SW-1:0]     scaled;

   logic [XW-1:0]     dx_ff, dx_in;
   logic [TW-1:0]     ylo_d_ff, ylo_d_in;
   logic [DW-1:0]     ydiff_ff, ydiff_in;
   logic              top_d_ff, top_d_in, neg_d_ff;
   logic [TW-1:0]     yhi;

   logic [NW-1:0]     num_ff, num_in;
   logic [TW-1:0]     ylo_m_ff;
   logic              top_m_ff, neg_m_ff;

   logic [PW-1:0]     prod;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [TW-1:0]     ylo_q_ff;
   logic              top_q_ff, neg_q_ff;

   logic [SUM_W-1:0]  sum;
   logic [TW-1:0]     mag;
   logic [RW-1:0]     sine_ff, sine_in;

   assign load_o   = !ov_ff || dn_ready;
   assign load_q   = !qv_ff || load_o;
   assign load_m   = !mv_ff || load_q;
   assign load_d   = !dv_ff || load_m;
   assign load_i   = !iv_ff || load_d;
   assign up_ready = load_i;

   assign iv_in = load_i ? up_valid : iv_ff;
   assign dv_in = load_d ? iv_ff : dv_ff;
   assign mv_in = load_m ? dv_ff : mv_ff;
   assign qv_in = load_q ? mv_ff : qv_ff;
   assign ov_in = load_o ? qv_ff : ov_ff;

   always_comb begin
      scaled = {up_fold.angle, fsi_pkg::TABLE_STEPS_W'(0)};
      idx_in = '0;
      for (int i = 1; i <= fsi_pkg::TABLE_STEPS; i++) begin
         if (64'(scaled) >= 64'(i) * 64'(HALF_PI_UNITS)) begin
            idx_in = IW'(i);
         end
      end
   end

   always_comb begin
      top_d_in = (32'(idx_ff) == 32'(fsi_pkg::TABLE_STEPS));
      dx_in    = XW'(32'(ang_ff) - 32'(idx_ff) * 32'(STEP_UNITS));
      ylo_d_in = fsi_pkg::quarter_wave(idx_ff);
      yhi      = fsi_pkg::quarter_wave(IW'(idx_ff + 1'b1));
      if (top_d_in) begin
         ydiff_in = '0;
      end else begin
         ydiff_in = DW'(yhi - ylo_d_in);
      end
   end

   assign num_in = NW'(18'(dx_ff) * 18'(ydiff_ff)) + NW'(HALF_STEP);

   assign prod   = PW'(num_ff) * PW'(RECIP);
   assign quo_in = prod[fsi_pkg::RECIP_SHIFT +: QW];

   always_comb begin
      sum = SUM_W'(quo_ff) + SUM_W'(ylo_q_ff);
      if (top_q_ff || (32'(sum) > 32'(fsi_pkg::SINE_ONE))) begin
         mag = TW'(fsi_pkg::SINE_ONE);
      end else begin
         mag = sum[TW-1:0];
      end
      if (neg_q_ff) begin
         sine_in = RW'(0) - RW'(mag);
      end else begin
         sine_in = RW'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= 1'b0;
         dv_ff <= 1'b0;
         mv_ff <= 1'b0;
         qv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         iv_ff <= iv_in;
         dv_ff <= dv_in;
         mv_ff <= mv_in;
         qv_ff <= qv_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_i && up_valid) begin
         idx_ff   <= idx_in;
         ang_ff   <= up_fold.angle;
         neg_i_ff <= up_fold.neg;
      end
      if (load_d && iv_ff) begin
         dx_ff    <= dx_in;
         ylo_d_ff <= ylo_d_in;
         ydiff_ff <= ydiff_in;
         top_d_ff <= top_d_in;
         neg_d_ff <= neg_i_ff;
      end
      if (load_m && dv_ff) begin
         num_ff   <= num_in;
         ylo_m_ff <= ylo_d_ff;
         top_m_ff <= top_d_ff;
         neg_m_ff <= neg_d_ff;
      end
      if (load_q && mv_ff) begin
         quo_ff   <= quo_in;
         ylo_q_ff <= ylo_m_ff;
         top_q_ff <= top_m_ff;
         neg_q_ff <= neg_m_ff;
      end
      if (load_o && qv_ff) begin
         sine_ff <= sine_in;
      end
   end

   assign dn_valid = ov_ff;
   assign dn_sine  = sine_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      iv_ff |-> 32'(idx_ff) <= 32'(fsi_pkg::TABLE_STEPS))
      else $error("table index beyond last entry");

   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> ($signed(sine_ff) <= $signed(RW'(fsi_pkg::SINE_ONE)))
             && ($signed(sine_ff) >= $signed(RW'(-fsi_pkg::SINE_ONE))))
      else $error("sine beyond full scale");

   a_top_hold: assert property (@(posedge clock) disable iff (reset)
      (dv_ff && top_d_ff) |-> (ydiff_ff == '0))
      else $error("last table entry carries a slope");

endmodule

FILE: hdl/fixed_point_sine_interp_top.sv
// Top level of the fixed-point sine pipeline: offset stage, modulo slices,
// fold and interpolation. Depends on fsi_pkg, fsi_mod_stage, fsi_fold, fsi_interp.
//
//   channel | dir | ports          | payload (low bit up)
//   req     | in  | req_t*         | tdata[31:0] angle (signed)
//   rsp     | out | rsp_t*         | tdata[11:0] sine_value (signed), [15:12] zero
//
// One beat enters per cycle unless the response side stalls. The modulo reduction
// takes 33 - bits of TWO_PI_UNITS + 1 compare-subtract steps.
// The modulo slices, seven compare-subtract steps each, set the depth.
// Synchronous reset clears all valid bits; payload registers are not reset.
// Each stage holds while its successor is full and stalled; bubbles collapse.
module fixed_point_sine_interp_top #(
   parameter int PI_UNITS      = fsi_pkg::PI_UNITS_DEF,
   parameter int HALF_PI_UNITS = fsi_pkg::HALF_PI_UNITS_DEF,
   parameter int TWO_PI_UNITS  = fsi_pkg::TWO_PI_UNITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fsi_pkg::ANGLE_W-1:0]    req_tdata,   // [31:0] angle
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fsi_pkg::RSP_DATA_W-1:0] rsp_tdata    // [11:0] sine_value
);

   localparam int RW        = fsi_pkg::REM_W;
   localparam int TWO_W     = $clog2(TWO_PI_UNITS + 1);
   localparam int TOP_SHIFT = RW - TWO_W;
   localparam int N_RED     = TOP_SHIFT + 1;
   localparam int N_MS      =
      (N_RED + fsi_pkg::RED_PER_STAGE - 1) / fsi_pkg::RED_PER_STAGE;
   localparam longint K_WRAP  = ((64'd1 << 31) + TWO_PI_UNITS - 1) / TWO_PI_UNITS;
   localparam longint OFFSET  = PI_UNITS + K_WRAP * TWO_PI_UNITS;
   localparam logic signed [RW-1:0] POS_PI = RW'(PI_UNITS);
   localparam logic signed [RW-1:0] NEG_PI = RW'(-PI_UNITS);

   logic                   v0_ff, v0_in;
   logic [RW-1:0]          x_ff, x_in;
   fsi_pkg::wrap_side_type side0_ff, side0_in;
   logic [RW-1:0]          ext;
   logic                   load0;

   logic [N_MS:0]          valid_c, ready_c;
   logic [RW-1:0]          rem_c  [N_MS+1];
   fsi_pkg::wrap_side_type side_c [N_MS+1];

   logic                   fold_valid, fold_ready;
   fsi_pkg::fold_type      fold;
   logic [fsi_pkg::RES_W-1:0] sine;

   assign ext            = {req_tdata[fsi_pkg::ANGLE_W-1], req_tdata};
   assign x_in           = ext + RW'(OFFSET);
   assign side0_in.below = $signed(ext) < NEG_PI;
   assign side0_in.above = $signed(ext) > POS_PI;
   assign side0_in.mid   = ext[fsi_pkg::MID_W-1:0];

   assign load0      = !v0_ff || ready_c[0];
   assign req_tready = load0;
   assign v0_in      = load0 ? req_tvalid : v0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load0 && req_tvalid) begin
         x_ff     <= x_in;
         side0_ff <= side0_in;
      end
   end

   assign valid_c[0] = v0_ff;
   assign rem_c[0]   = x_ff;
   assign side_c[0]  = side0_ff;

   for (genvar s = 0; s < N_MS; s++) begin : g_mod
      fsi_mod_stage #(
         .TWO_PI_UNITS (TWO_PI_UNITS),
         .TOP_SHIFT    (TOP_SHIFT - s * fsi_pkg::RED_PER_STAGE),
         .STEPS        (fsi_pkg::RED_PER_STAGE)
      ) u_mod (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_c[s]),
         .up_ready (ready_c[s]),
         .up_rem   (rem_c[s]),
         .up_side  (side_c[s]),
         .dn_valid (valid_c[s+1]),
         .dn_ready (ready_c[s+1]),
         .dn_rem   (rem_c[s+1]),
         .dn_side  (side_c[s+1])
      );
   end

   fsi_fold #(
      .PI_UNITS      (PI_UNITS),
      .HALF_PI_UNITS (HALF_PI_UNITS),
      .TWO_PI_UNITS  (TWO_PI_UNITS)
   ) u_fold (
      .clock    (clock),
      .reset    (reset),
      .up_valid (valid_c[N_MS]),
      .up_ready (ready_c[N_MS]),
      .up_rem   (rem_c[N_MS]),
      .up_side  (side_c[N_MS]),
      .dn_valid (fold_valid),
      .dn_ready (fold_ready),
      .dn_fold  (fold)
   );

   fsi_interp #(
      .HALF_PI_UNITS (HALF_PI_UNITS)
   ) u_interp (
      .clock    (clock),
      .reset    (reset),
      .up_valid (fold_valid),
      .up_ready (fold_ready),
      .up_fold  (fold),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_sine  (sine)
   );

   assign rsp_tdata = {(fsi_pkg::RSP_DATA_W - fsi_pkg::RES_W)'(0), sine};

endmodule
